@@ hw/rtl/pal_pkg.sv @@
`default_nettype none

package pal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_CHANGE = 2'd3
    } pal_cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_POS  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } pal_status_t;

    typedef struct packed {
        pal_cmd_t                  command;
        logic [4:0]                position;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  new_value;
    } pal_item_t;

    typedef struct packed {
        pal_status_t  status;
        logic [4:0]   found_position;
        logic [4:0]   list_length;
    } pal_result_t;

    typedef struct packed {
        logic                      en;
        logic [IDX_W-1:0]          addr;
        logic signed [DATA_W-1:0]  data;
    } pal_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/pal_store.sv @@
`default_nettype none

module pal_store (
    input  wire logic                              clk,
    input  wire pal_pkg::pal_wr_t                  wr,
    input  wire logic [pal_pkg::IDX_W-1:0]         rd_addr,
    output logic signed [pal_pkg::DATA_W-1:0]      rd_data
);
    import pal_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/pal_seq.sv @@
`default_nettype none

module pal_seq (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire pal_pkg::pal_item_t                item,
    output logic                                   busy,
    output logic                                   done,
    output pal_pkg::pal_result_t                   result,
    output pal_pkg::pal_wr_t                       wr,
    output logic [pal_pkg::IDX_W-1:0]              rd_addr,
    input  wire logic signed [pal_pkg::DATA_W-1:0] rd_data
);
    import pal_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SEARCH
    } state_t;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    state_t                   state_reg, state_next;
    pal_cmd_t                 cmd_reg, cmd_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] nval_reg, nval_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         pidx_reg, pidx_next;
    pal_result_t              res_reg, res_next;
    logic                     done_reg, done_next;

    logic [CNT_W-1:0] pos_m1;
    logic             ins_bad;
    logic             del_bad;
    logic             match;

    assign pos_m1  = item.position - ONE;
    assign ins_bad = (item.position == '0) ||
                     ({1'b0, item.position} > ({1'b0, cnt_reg} + (CNT_W+1)'(1)));
    assign del_bad = (item.position == '0) || (item.position > cnt_reg);
    // shared compare against the key
    assign match   = (rd_data == val_reg);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        nval_next  = nval_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        wr         = '0;
        rd_addr    = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = item.command;
                    val_next  = item.value;
                    nval_next = item.new_value;
                    k_next    = pos_m1[IDX_W-1:0];
                    res_next.found_position = '0;
                    res_next.list_length    = cnt_reg;
                    unique case (item.command)
                        CMD_INSERT:
                        begin
                            priority if (ins_bad)
                            begin
                                res_next.status = ST_BAD_POS;
                                done_next       = 1'b1;
                            end
                            else if (cnt_reg == CAP_CNT)
                            begin
                                res_next.status = ST_FULL;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                // walk from the top entry down to the insert slot
                                ptr_next   = cnt_reg - ONE;
                                rem_next   = cnt_reg - pos_m1;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (del_bad)
                            begin
                                res_next.status = ST_BAD_POS;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = item.position;
                                rem_next   = cnt_reg - item.position;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_FIND, CMD_CHANGE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_NOTFOUND;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                rem_next   = cnt_reg;
                                state_next = S_SEARCH;
                            end
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                if (rem_reg != '0)
                begin
                    ptr_next  = (cmd_reg == CMD_INSERT) ? ptr_reg - ONE : ptr_reg + ONE;
                    rem_next  = rem_reg - ONE;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                end
                // read data is registered, so it lands in the cycle after its address
                if (pend_reg)
                begin
                    wr.en   = 1'b1;
                    wr.addr = (cmd_reg == CMD_INSERT) ? pidx_reg + IDX_W'(1)
                                                      : pidx_reg - IDX_W'(1);
                    wr.data = rd_data;
                end
                else if (rem_reg == '0)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        wr.en    = 1'b1;
                        wr.addr  = k_reg;
                        wr.data  = val_reg;
                        cnt_next = cnt_reg + ONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - ONE;
                    end
                    res_next.status         = ST_OK;
                    res_next.found_position = '0;
                    res_next.list_length    = cnt_next;
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                if (rem_reg != '0)
                begin
                    ptr_next  = ptr_reg + ONE;
                    rem_next  = rem_reg - ONE;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                end
                if (pend_reg && match)
                begin
                    if (cmd_reg == CMD_CHANGE)
                    begin
                        wr.en   = 1'b1;
                        wr.addr = pidx_reg;
                        wr.data = nval_reg;
                    end
                    res_next.status         = ST_OK;
                    res_next.found_position = CNT_W'(pidx_reg) + ONE;
                    res_next.list_length    = cnt_reg;
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
                else if (!pend_reg && rem_reg == '0)
                begin
                    res_next.status         = ST_NOTFOUND;
                    res_next.found_position = '0;
                    res_next.list_length    = cnt_reg;
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        val_reg  <= val_next;
        nval_reg <= nval_next;
        k_reg    <= k_next;
        ptr_reg  <= ptr_next;
        rem_reg  <= rem_next;
        pidx_reg <= pidx_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> busy)
        else $error("store written while idle");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_NOTFOUND) |-> (result.found_position == '0))
        else $error("not-found beat carries a position");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(state_reg == S_SHIFT))
        else $error("count changed outside a shift pass");

    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.list_length == cnt_reg))
        else $error("reported length differs from count");

endmodule

`default_nettype wire

@@ hw/rtl/positional_array_list_engine.sv @@
`default_nettype none

// Ordered list of up to 16 signed 32-bit entries held in a single-port-read store.
// A command is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with done high, and it must be captured then since
// there is no way to hold it off. Rejected commands (bad position, full list, find
// or change on an empty list) give their beat in the cycle after acceptance.
// Insert at position p moves each entry from the last down to p up by one, then
// writes the value at p; delete moves each entry after p down by one; find and
// change compare entries from the first on until a match or the list's end. The
// store's one read port moves or compares one entry per cycle. busy drops in the
// cycle the result beat appears, so the next command may be taken alongside it.
module positional_array_list_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pal_pkg::pal_item_t   item,
    output logic                      done,
    output pal_pkg::pal_result_t      result
);
    import pal_pkg::*;

    pal_wr_t                  wr;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    pal_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pal_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire
